// ----- hdl/kcl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants of the keypad code lock
// Key codes, command digits, register indexes, the default password and the
// status bundle that the run matcher returns to the control logic.
// ----------------------------------------------------------------------------
package kcl_pkg;

  typedef logic [3:0] digit_t;

  // input item kinds
  localparam logic IN_KEY  = 1'b0;
  localparam logic IN_TICK = 1'b1;

  // key codes
  localparam digit_t KEY_DIGIT_MAX = 4'd9;
  localparam digit_t KEY_STAR      = 4'd10;
  localparam digit_t KEY_HASH      = 4'd11;

  // command digits typed after star
  localparam digit_t CMD_KEY_DELETE = 4'd0;
  localparam digit_t CMD_KEY_ENROLL = 4'd1;
  localparam digit_t CMD_KEY_CHANGE = 4'd2;
  localparam digit_t CMD_KEY_RADIO  = 4'd7;

  // codes reported for outside action
  localparam logic [1:0] CMD_DELETE = 2'd0;
  localparam logic [1:0] CMD_ENROLL = 2'd1;
  localparam logic [1:0] CMD_RADIO  = 2'd2;

  // configuration register indexes
  localparam logic CFG_MAX_ERRORS = 1'b0;
  localparam logic CFG_MIN_NEW_LEN = 1'b1;

  // configuration reset values
  localparam logic [3:0] MAX_ERRORS_RST = 4'd3;
  localparam logic [3:0] MIN_NEW_LEN_RST = 4'd6;

  // default password: 0 2 0 0 3 5
  localparam int PW_RESET_LEN = 6;

  function automatic digit_t kcl_pw_reset(input int idx);
    digit_t d;
    d = 4'd0;
    if (idx == 1) d = 4'd2;
    if (idx == 4) d = 4'd3;
    if (idx == 5) d = 4'd5;
    return d;
  endfunction

  // matcher status
  typedef struct packed {
    logic done;
    logic hit;
  } kcl_scan_t;

endpackage

// ----- hdl/kcl_matcher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_matcher: contiguous-run search of the password in the typed entry
// Loads the entry into a window shift register and slides it one digit per
// cycle; each cycle compares all password digits against the window at once.
// ----------------------------------------------------------------------------
module kcl_matcher import kcl_pkg::*; #(
  parameter int MAX_DIGITS = 15,
  parameter int CW         = $clog2(MAX_DIGITS + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  digit_t [MAX_DIGITS-1:0]        entry,
  input  logic [CW-1:0]                  tlen,
  input  digit_t [MAX_DIGITS-1:0]        pw,
  input  logic [CW-1:0]                  plen,
  output kcl_scan_t                      res
);

  digit_t [MAX_DIGITS-1:0] win_r, win_nxt;
  logic [CW-1:0]           left_r, left_nxt;
  logic                    busy_r, busy_nxt;
  kcl_scan_t               res_r, res_nxt;
  logic                    win_eq;

  // compare the active password lanes against the window
  always_comb begin
    win_eq = 1'b1;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (CW'(k) < plen && win_r[k] != pw[k]) win_eq = 1'b0;
    end
  end

  // advance the search one start offset per cycle
  always_comb begin
    win_nxt  = win_r;
    left_nxt = left_r;
    busy_nxt = busy_r;
    res_nxt  = '0;
    if (start) begin
      win_nxt = entry;
      if (plen > tlen) begin
        res_nxt.done = 1'b1;
        busy_nxt     = 1'b0;
      end else begin
        left_nxt = tlen - plen + CW'(1);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (win_eq) begin
        res_nxt.done = 1'b1;
        res_nxt.hit  = 1'b1;
        busy_nxt     = 1'b0;
      end else if (left_r == CW'(1)) begin
        res_nxt.done = 1'b1;
        busy_nxt     = 1'b0;
      end else begin
        left_nxt = left_r - CW'(1);
        for (int k = 0; k < MAX_DIGITS - 1; k++) win_nxt[k] = win_r[k+1];
        win_nxt[MAX_DIGITS-1] = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      res_r  <= '0;
      left_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      res_r  <= res_nxt;
      left_r <= left_nxt;
    end
  end

  // hold the window; it needs no reset
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  assign res = res_r;

  // a running search always has an offset left to try
  a_busy_left: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> left_r != '0)
    else $error("matcher busy with no offsets left");

  // a result is never reported while the search keeps running
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.done |-> !busy_r)
    else $error("matcher reported done while busy");

  // a hit only comes with a finished search
  a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.hit |-> res_r.done)
    else $error("matcher hit without done");

endmodule

// ----- hdl/keypad_code_lock_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_code_lock_core: keypad code lock with buffered entry
// Buffers digits, checks the password as a run anywhere in the entry,
// handles command mode, two-pass password change and failure lockout.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   input   | in_valid in_stall in_cmd in_key     | in
//   result  | out_valid out_stall out_unlock ...  | out
//   config  | cfg_we cfg_index cfg_wdata          | in
//
// An item without a password check goes from accept through ST_EXEC to its result.
// A star or hash that checks the password waits in ST_SCAN while the matcher
// slides one start offset per cycle, and then passes ST_EXEC.
// One item is worked on at a time; a waiting result does not block accept.
// rst_n is synchronous; it restores the default password and registers.
// ----------------------------------------------------------------------------
module keypad_code_lock_core import kcl_pkg::*; #(
  parameter int MAX_DIGITS = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [3:0] in_key,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_unlock,
  output logic       out_rejected,
  output logic       out_command_valid,
  output logic [1:0] out_command_code,
  output logic       out_password_changed,
  output logic       out_locked_out,
  output logic [3:0] out_error_count,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [3:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int LW = (CW > 4) ? CW : 4;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EXEC} state_t;

  state_t state_r, state_nxt;

  digit_t [MAX_DIGITS-1:0] entry_r, entry_nxt;
  digit_t [MAX_DIGITS-1:0] pend_r, pend_nxt;
  digit_t [MAX_DIGITS-1:0] pw_r, pw_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] stage_r, stage_nxt;
  logic [CW-1:0] pwlen_r, pwlen_nxt;
  logic          armed_r, armed_nxt;
  logic [3:0]    fail_r, fail_nxt;
  logic [3:0]    max_err_r, max_err_nxt;
  logic [3:0]    min_len_r, min_len_nxt;
  logic          hit_r, hit_nxt;
  logic          item_cmd_r;
  digit_t        item_key_r;

  logic       out_valid_r, out_valid_nxt;
  logic       unlock_r, unlock_nxt;
  logic       rej_r, rej_nxt;
  logic       cv_r, cv_nxt;
  logic [1:0] cc_r, cc_nxt;
  logic       chg_r, chg_nxt;
  logic       lock_r, lock_nxt;
  logic [3:0] errs_r, errs_nxt;

  logic      in_accept;
  logic      out_free;
  logic      locked;
  logic      need_scan;
  logic      scan_start;
  logic      pend_eq;
  logic      len_ok;
  logic [3:0] min_len;
  kcl_scan_t scan_res;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign locked    = (fail_r >= max_err_r);
  assign min_len   = (min_len_r == 4'd0) ? 4'd1 : min_len_r;
  assign len_ok    = (LW'(count_r) >= LW'(min_len));

  // items that need a password search before they can act
  assign need_scan = (in_cmd == IN_KEY) && !locked && (count_r != '0) && !armed_r &&
                     ((in_key == KEY_STAR) || (in_key == KEY_HASH && stage_r == '0));
  assign scan_start = in_accept && need_scan;

  // confirmation digits against the first new entry
  always_comb begin
    pend_eq = 1'b1;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (CW'(k) < count_r && pend_r[k] != entry_r[k]) pend_eq = 1'b0;
    end
  end

  kcl_matcher #(
    .MAX_DIGITS (MAX_DIGITS),
    .CW         (CW)
  ) u_matcher (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .entry (entry_r),
    .tlen  (count_r),
    .pw    (pw_r),
    .plen  (pwlen_r),
    .res   (scan_res)
  );

  // sequence one item and apply its effect
  always_comb begin
    state_nxt     = state_r;
    entry_nxt     = entry_r;
    pend_nxt      = pend_r;
    pw_nxt        = pw_r;
    count_nxt     = count_r;
    stage_nxt     = stage_r;
    pwlen_nxt     = pwlen_r;
    armed_nxt     = armed_r;
    fail_nxt      = fail_r;
    max_err_nxt   = max_err_r;
    min_len_nxt   = min_len_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && out_stall;
    unlock_nxt    = unlock_r;
    rej_nxt       = rej_r;
    cv_nxt        = cv_r;
    cc_nxt        = cc_r;
    chg_nxt       = chg_r;
    lock_nxt      = lock_r;
    errs_nxt      = errs_r;

    if (cfg_we && cfg_index == CFG_MAX_ERRORS) max_err_nxt = cfg_wdata;
    if (cfg_we && cfg_index == CFG_MIN_NEW_LEN) min_len_nxt = cfg_wdata;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = need_scan ? ST_SCAN : ST_EXEC;
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          hit_nxt   = scan_res.hit;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          unlock_nxt = 1'b0;
          rej_nxt    = 1'b0;
          cv_nxt     = 1'b0;
          cc_nxt     = CMD_DELETE;
          chg_nxt    = 1'b0;
          if (item_cmd_r == IN_TICK) begin
            // drop entry, command mode and any change in progress
            count_nxt = '0;
            armed_nxt = 1'b0;
            stage_nxt = '0;
          end else if (locked) begin
            // ignore keys while locked out
          end else if (item_key_r <= KEY_DIGIT_MAX) begin
            if (count_r < CW'(MAX_DIGITS)) begin
              for (int k = 0; k < MAX_DIGITS; k++) begin
                if (CW'(k) == count_r) entry_nxt[k] = item_key_r;
              end
              count_nxt = count_r + CW'(1);
            end else begin
              rej_nxt = 1'b1;
              if (fail_r < max_err_r) fail_nxt = fail_r + 4'd1;
              count_nxt = '0;
              armed_nxt = 1'b0;
            end
          end else if (item_key_r == KEY_STAR && count_r != '0) begin
            if (!armed_r) begin
              if (hit_r) begin
                armed_nxt = 1'b1;
              end else begin
                rej_nxt = 1'b1;
                if (fail_r < max_err_r) fail_nxt = fail_r + 4'd1;
              end
            end else begin
              armed_nxt = 1'b0;
            end
            count_nxt = '0;
            stage_nxt = '0;
          end else if (item_key_r == KEY_HASH && count_r != '0) begin
            if (!armed_r && stage_r == '0) begin
              // plain unlock attempt
              if (hit_r) begin
                unlock_nxt = 1'b1;
                fail_nxt   = 4'd0;
              end else begin
                rej_nxt = 1'b1;
                if (fail_r < max_err_r) fail_nxt = fail_r + 4'd1;
              end
            end else if (!armed_r) begin
              // password change passes
              if (stage_r == CW'(1) && len_ok) begin
                pend_nxt  = entry_r;
                stage_nxt = count_r;
              end else if (stage_r == count_r && len_ok) begin
                if (pend_eq) begin
                  for (int k = 0; k < MAX_DIGITS; k++) begin
                    pw_nxt[k] = (CW'(k) < count_r) ? pend_r[k] : 4'd0;
                  end
                  pwlen_nxt = count_r;
                  chg_nxt   = 1'b1;
                end
                stage_nxt = '0;
              end else begin
                stage_nxt = '0;
              end
            end else begin
              // command digit in armed mode
              if (count_r == CW'(1)) begin
                case (entry_r[0])
                  CMD_KEY_DELETE: begin
                    cv_nxt = 1'b1;
                    cc_nxt = CMD_DELETE;
                  end
                  CMD_KEY_ENROLL: begin
                    cv_nxt = 1'b1;
                    cc_nxt = CMD_ENROLL;
                  end
                  CMD_KEY_CHANGE: begin
                    stage_nxt = CW'(1);
                  end
                  CMD_KEY_RADIO: begin
                    cv_nxt = 1'b1;
                    cc_nxt = CMD_RADIO;
                  end
                  default: begin
                  end
                endcase
              end
              armed_nxt = 1'b0;
            end
            count_nxt = '0;
          end
          lock_nxt      = (fail_nxt >= max_err_r);
          errs_nxt      = fail_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // hold state, lock registers and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      stage_r     <= '0;
      armed_r     <= 1'b0;
      fail_r      <= 4'd0;
      max_err_r   <= MAX_ERRORS_RST;
      min_len_r   <= MIN_NEW_LEN_RST;
      pwlen_r     <= CW'(PW_RESET_LEN);
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
      unlock_r    <= 1'b0;
      rej_r       <= 1'b0;
      cv_r        <= 1'b0;
      cc_r        <= CMD_DELETE;
      chg_r       <= 1'b0;
      lock_r      <= 1'b0;
      errs_r      <= 4'd0;
      for (int k = 0; k < MAX_DIGITS; k++) pw_r[k] <= kcl_pw_reset(k);
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      stage_r     <= stage_nxt;
      armed_r     <= armed_nxt;
      fail_r      <= fail_nxt;
      max_err_r   <= max_err_nxt;
      min_len_r   <= min_len_nxt;
      pwlen_r     <= pwlen_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
      unlock_r    <= unlock_nxt;
      rej_r       <= rej_nxt;
      cv_r        <= cv_nxt;
      cc_r        <= cc_nxt;
      chg_r       <= chg_nxt;
      lock_r      <= lock_nxt;
      errs_r      <= errs_nxt;
      pw_r        <= pw_nxt;
    end
  end

  // hold the digit buffers and the accepted item
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    pend_r  <= pend_nxt;
    if (in_accept) begin
      item_cmd_r <= in_cmd;
      item_key_r <= in_key;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_unlock           = unlock_r;
  assign out_rejected         = rej_r;
  assign out_command_valid    = cv_r;
  assign out_command_code     = cc_r;
  assign out_password_changed = chg_r;
  assign out_locked_out       = lock_r;
  assign out_error_count      = errs_r;

  // a search finishes only while the item waits for it
  a_scan_state: assert property (@(posedge clk) disable iff (!rst_n)
    scan_res.done |-> state_r == ST_SCAN)
    else $error("search result outside of scan state");

  // an unlock always comes with a cleared error count
  a_unlock_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && unlock_r |-> errs_r == 4'd0)
    else $error("unlock with nonzero error count");

  // at most one kind of event per result
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $countones({unlock_r, rej_r, cv_r, chg_r}) <= 1)
    else $error("several events in one result");

  // command code is zero unless a command is requested
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !cv_r |-> cc_r == CMD_DELETE)
    else $error("command code set without a command");

  // armed mode and a password change never coexist
  a_arm_stage: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> stage_r == '0)
    else $error("armed during password change");

endmodule

// ----- test/kcl_lock_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_lock_checker: result predictor and scoreboard for the keypad code lock
// Watches the input, result and configuration ports of the lock core, keeps
// its own copy of the lock state, predicts one result per accepted item and
// compares every accepted result field by field with the oldest prediction.
// It also exposes the predicted password and error state to the stimulus.
// ----------------------------------------------------------------------------
module kcl_lock_checker import kcl_pkg::*; #(
  parameter int MAX_DIGITS = 15
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [3:0]                  in_key,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_unlock,
  input  logic                        out_rejected,
  input  logic                        out_command_valid,
  input  logic [1:0]                  out_command_code,
  input  logic                        out_password_changed,
  input  logic                        out_locked_out,
  input  logic [3:0]                  out_error_count,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [3:0]                  cfg_wdata,
  output int                          errors,
  output int                          results_seen,
  output int                          expect_left,
  output logic [MAX_DIGITS-1:0][3:0]  code_view,
  output logic [3:0]                  code_len_view,
  output logic [3:0]                  fails_view,
  output logic                        locked_view
);

  typedef struct packed {
    logic       unlock;
    logic       rejected;
    logic       command_valid;
    logic [1:0] command_code;
    logic       password_changed;
    logic       locked_out;
    logic [3:0] error_count;
  } lock_result_t;

  // predicted lock state
  digit_t entry [MAX_DIGITS];
  int     entry_len;
  bit     armed;
  int     stage;
  digit_t pend [MAX_DIGITS];
  digit_t code [MAX_DIGITS];
  int     code_len;
  int     fails;
  int     max_err;
  int     min_len;

  lock_result_t lock_results_q [$];
  lock_result_t head;

  function automatic void clear_entry();
    int i;
    for (i = 0; i < MAX_DIGITS; i++) entry[i] = '0;
    entry_len = 0;
  endfunction

  function automatic void reset_lock();
    int i;
    max_err = int'(MAX_ERRORS_RST);
    min_len = int'(MIN_NEW_LEN_RST);
    clear_entry();
    armed = 1'b0;
    stage = 0;
    for (i = 0; i < MAX_DIGITS; i++) begin
      pend[i] = '0;
      code[i] = '0;
    end
    // factory code 0 2 0 0 3 5
    code[1] = 4'd2;
    code[4] = 4'd3;
    code[5] = 4'd5;
    code_len = 6;
    fails = 0;
  endfunction

  // true when the stored code occurs as a contiguous run in the entry
  function automatic bit entry_holds_code();
    int s;
    int k;
    bit hit;
    bit same;
    hit = 1'b0;
    for (s = 0; s + code_len <= entry_len; s++) begin
      same = 1'b1;
      for (k = 0; k < code_len; k++)
        if (entry[s + k] != code[k]) same = 1'b0;
      if (same) hit = 1'b1;
    end
    return hit;
  endfunction

  // advance the lock by one item and queue the result it must give
  task automatic predict_lock_result(input logic cmd, input digit_t key);
    lock_result_t r;
    bit failed;
    bit same;
    int floor_len;
    int i;
    r = '0;
    failed = 1'b0;
    floor_len = (min_len == 0) ? 1 : min_len;
    if (cmd == IN_TICK) begin
      clear_entry();
      armed = 1'b0;
      stage = 0;
    end else if (fails < max_err) begin
      if (key <= KEY_DIGIT_MAX) begin
        if (entry_len < MAX_DIGITS) begin
          entry[entry_len] = key;
          entry_len++;
        end else begin
          // overflow: count a failure and drop the entry
          failed = 1'b1;
          clear_entry();
          armed = 1'b0;
        end
      end else if (key == KEY_STAR && entry_len > 0) begin
        if (!armed) begin
          if (entry_holds_code()) armed = 1'b1;
          else failed = 1'b1;
        end else begin
          armed = 1'b0;
        end
        clear_entry();
        stage = 0;
      end else if (key == KEY_HASH && entry_len > 0) begin
        if (!armed && stage == 0) begin
          if (entry_holds_code()) begin
            r.unlock = 1'b1;
            fails = 0;
          end else begin
            failed = 1'b1;
          end
        end else if (!armed) begin
          // password change: first entry, then confirmation
          if (stage == 1 && entry_len >= floor_len) begin
            for (i = 0; i < MAX_DIGITS; i++) pend[i] = entry[i];
            stage = entry_len;
          end else if (stage == entry_len && entry_len >= floor_len) begin
            same = 1'b1;
            for (i = 0; i < entry_len; i++)
              if (pend[i] != entry[i]) same = 1'b0;
            if (same) begin
              for (i = 0; i < MAX_DIGITS; i++) code[i] = (i < entry_len) ? pend[i] : '0;
              code_len = entry_len;
              r.password_changed = 1'b1;
            end
            stage = 0;
          end else begin
            stage = 0;
          end
        end else begin
          // armed: a single command digit selects the action
          if (entry_len == 1) begin
            case (entry[0])
              CMD_KEY_DELETE: begin
                r.command_valid = 1'b1;
                r.command_code = CMD_DELETE;
              end
              CMD_KEY_ENROLL: begin
                r.command_valid = 1'b1;
                r.command_code = CMD_ENROLL;
              end
              CMD_KEY_CHANGE: stage = 1;
              CMD_KEY_RADIO: begin
                r.command_valid = 1'b1;
                r.command_code = CMD_RADIO;
              end
              default: ;
            endcase
          end
          armed = 1'b0;
        end
        clear_entry();
      end
    end
    if (failed) begin
      r.rejected = 1'b1;
      if (fails < max_err && fails < 15) fails++;
    end
    r.locked_out = (fails >= max_err);
    r.error_count = fails[3:0];
    lock_results_q.push_back(r);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_lock();
      lock_results_q.delete();
    end else begin
      // compare an accepted result with the oldest prediction
      if (out_valid && !out_stall) begin
        results_seen++;
        if (lock_results_q.size() == 0) begin
          $error("result with no item waiting");
          errors++;
        end else begin
          head = lock_results_q.pop_front();
          check_field("unlock", head.unlock, out_unlock);
          check_field("rejected", head.rejected, out_rejected);
          check_field("command_valid", head.command_valid, out_command_valid);
          check_field("command_code", head.command_code, out_command_code);
          check_field("password_changed", head.password_changed, out_password_changed);
          check_field("locked_out", head.locked_out, out_locked_out);
          check_field("error_count", head.error_count, out_error_count);
        end
      end
      if (in_valid && !in_stall) predict_lock_result(in_cmd, in_key);
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_ERRORS:  max_err = int'(cfg_wdata);
          CFG_MIN_NEW_LEN: min_len = int'(cfg_wdata);
          default: ;
        endcase
      end
    end
    // publish the predicted state for the stimulus
    expect_left <= lock_results_q.size();
    for (int i = 0; i < MAX_DIGITS; i++) code_view[i] <= code[i];
    code_len_view <= code_len[3:0];
    fails_view <= fails[3:0];
    locked_view <= (fails >= max_err);
  end

endmodule

// ----- test/tb_keypad_code_lock_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keypad_code_lock_core: testbench of the keypad code lock core
// Drives key presses and timeout ticks: a short opening sequence, then phases
// of random unlock, command, password change, overflow and noise sequences,
// each phase under new register settings. Both channels idle in random
// bursts, the receiver holds off once for a long stretch, and the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_keypad_code_lock_core;
  import kcl_pkg::*;

  localparam int MAX_DIGITS  = 15;
  localparam int N_RANDOM    = 1850;
  localparam int QUIET_TAIL  = 150;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PHASES  = 60;
  localparam int TAIL        = 40;
  localparam int LIMIT       = 1000000;

  typedef logic [4:0] press_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_cmd = 1'b0;
  logic [3:0] in_key = 4'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_unlock;
  logic       out_rejected;
  logic       out_command_valid;
  logic [1:0] out_command_code;
  logic       out_password_changed;
  logic       out_locked_out;
  logic [3:0] out_error_count;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;

  int                        chk_errors;
  int                        results_seen;
  int                        chk_left;
  logic [MAX_DIGITS-1:0][3:0] code_view;
  logic [3:0]                code_len_view;
  logic [3:0]                fails_view;
  logic                      locked_view;

  int     n_sent = 0;
  int     goal;
  int     cur_min = int'(MIN_NEW_LEN_RST);
  int     cycles = 0;
  bit     quiet = 1'b0;
  bit     gaps_on = 1'b1;
  bit     hold_done = 1'b0;
  bit     saw_lock;
  digit_t burst [$];

  // reset checks, empty star and hash, unused key codes, decoy unlock, command
  press_t opening [22] = '{
    {IN_TICK, 4'hF}, {IN_KEY, KEY_HASH}, {IN_KEY, KEY_STAR}, {IN_KEY, 4'd12},
    {IN_KEY, 4'd15},
    {IN_KEY, 4'd9}, {IN_KEY, 4'd0}, {IN_KEY, 4'd2}, {IN_KEY, 4'd0},
    {IN_KEY, 4'd0}, {IN_KEY, 4'd3}, {IN_KEY, 4'd5}, {IN_KEY, KEY_HASH},
    {IN_KEY, 4'd0}, {IN_KEY, 4'd2}, {IN_KEY, 4'd0}, {IN_KEY, 4'd0},
    {IN_KEY, 4'd3}, {IN_KEY, 4'd5}, {IN_KEY, KEY_STAR},
    {IN_KEY, CMD_KEY_RADIO}, {IN_KEY, KEY_HASH}
  };

  keypad_code_lock_core #(.MAX_DIGITS(MAX_DIGITS)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_key              (in_key),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_unlock          (out_unlock),
    .out_rejected        (out_rejected),
    .out_command_valid   (out_command_valid),
    .out_command_code    (out_command_code),
    .out_password_changed(out_password_changed),
    .out_locked_out      (out_locked_out),
    .out_error_count     (out_error_count),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  kcl_lock_checker #(.MAX_DIGITS(MAX_DIGITS)) lock_chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_key              (in_key),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_unlock          (out_unlock),
    .out_rejected        (out_rejected),
    .out_command_valid   (out_command_valid),
    .out_command_code    (out_command_code),
    .out_password_changed(out_password_changed),
    .out_locked_out      (out_locked_out),
    .out_error_count     (out_error_count),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .errors              (chk_errors),
    .results_seen        (results_seen),
    .expect_left         (chk_left),
    .code_view           (code_view),
    .code_len_view       (code_len_view),
    .fails_view          (fails_view),
    .locked_view         (locked_view)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // offer one item, hold it until accepted, then maybe idle
  task automatic push_item(input logic cmd, input digit_t key);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_key <= key;
    do @(posedge clk); while (in_stall);
    n_sent++;
    if (!quiet && gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // drop valid and wait until every item has its result
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_seen != n_sent);
  endtask

  task automatic write_reg(input logic idx, input logic [3:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_digits(input int n);
    repeat (n) burst.push_back(4'($urandom_range(0, 9)));
  endtask

  // current code, sometimes wrapped in decoy digits
  task automatic add_code_entry();
    int pre;
    int post;
    int k;
    pre = $urandom_range(0, 15 - int'(code_len_view));
    post = $urandom_range(0, 15 - int'(code_len_view) - pre);
    if ($urandom_range(0, 1) == 0) begin
      pre = 0;
      post = 0;
    end
    add_digits(pre);
    for (k = 0; k < code_len_view; k++) burst.push_back(code_view[k]);
    add_digits(post);
  endtask

  // one sequence, always opened by a timeout tick to start from a clean entry
  task automatic run_sequence();
    int k;
    int sel;
    int dlen;
    int pos;
    digit_t d;
    digit_t fresh [16];
    quiet = (n_sent + QUIET_TAIL >= goal);
    gaps_on = ($urandom_range(0, 3) != 0);
    burst.delete();
    push_item(IN_TICK, 4'($urandom_range(0, 15)));
    if (locked_view) begin
      // locked out: a few presses that must be ignored, then end the phase
      saw_lock = 1'b1;
      repeat ($urandom_range(3, 6)) push_item(IN_KEY, 4'($urandom_range(0, 15)));
      return;
    end
    case ($urandom_range(0, 9))
      0, 1: begin
        add_code_entry();
        burst.push_back(KEY_HASH);
      end
      2: begin
        add_digits($urandom_range(1, 15));
        burst.push_back(KEY_HASH);
      end
      3, 4: begin
        add_code_entry();
        burst.push_back(KEY_STAR);
        sel = $urandom_range(0, 5);
        case (sel)
          0: d = CMD_KEY_DELETE;
          1: d = CMD_KEY_ENROLL;
          2: d = CMD_KEY_RADIO;
          default: d = 4'($urandom_range(0, 9));
        endcase
        burst.push_back(d);
        if (sel == 5) add_digits($urandom_range(1, 3));
        burst.push_back(KEY_HASH);
      end
      5, 6: begin
        add_code_entry();
        burst.push_back(KEY_STAR);
        burst.push_back(CMD_KEY_CHANGE);
        burst.push_back(KEY_HASH);
        if ($urandom_range(0, 4) == 0) dlen = $urandom_range(1, 15);
        else dlen = $urandom_range(cur_min, (cur_min + 4 > 15) ? 15 : cur_min + 4);
        for (k = 0; k < 16; k++) fresh[k] = 4'($urandom_range(0, 9));
        for (k = 0; k < dlen; k++) burst.push_back(fresh[k]);
        burst.push_back(KEY_HASH);
        sel = $urandom_range(0, 9);
        if (sel == 7) begin
          // confirmation with one digit off
          pos = $urandom_range(0, dlen - 1);
          fresh[pos] = 4'((int'(fresh[pos]) + $urandom_range(1, 9)) % 10);
        end
        if (sel == 8) dlen = (dlen < 15) ? dlen + 1 : dlen - 1;
        if (sel == 9) begin
          // star in the middle cancels the change
          for (k = 0; k < $urandom_range(1, dlen); k++) burst.push_back(fresh[k]);
          burst.push_back(KEY_STAR);
        end else begin
          for (k = 0; k < dlen; k++) burst.push_back(fresh[k]);
        end
        burst.push_back(KEY_HASH);
      end
      7: begin
        add_digits(16);
        if ($urandom_range(0, 1) == 0) burst.push_back(KEY_HASH);
      end
      8: begin
        add_code_entry();
        burst.push_back(KEY_STAR);
        add_digits($urandom_range(1, 3));
        burst.push_back(KEY_STAR);
      end
      default: begin
        repeat ($urandom_range(1, 10))
          push_item($urandom_range(0, 9) == 0, 4'($urandom_range(0, 15)));
      end
    endcase
    foreach (burst[i]) push_item(IN_KEY, burst[i]);
  endtask

  // receiver: random stall bursts, one long hold-off, none at the end
  initial begin
    do @(posedge clk); while (!rst_n);
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!hold_done && n_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    int phase;
    int phase_end;
    logic [3:0] mx;
    logic [3:0] mn;
    goal = $size(opening) + N_RANDOM;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening[i]) push_item(opening[i][4], opening[i][3:0]);

    for (phase = 0; n_sent < goal && phase < MAX_PHASES; phase++) begin
      wait_idle();
      // an error count stuck at the top cannot be lifted; restart the lock
      if (locked_view && fails_view == 4'd15) begin
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
      end
      // pick settings; lift the error limit past the count when locked out
      if (locked_view && fails_view < 15) mx = 4'($urandom_range(int'(fails_view) + 1, 15));
      else if (phase == 0) mx = 4'd15;
      else if (phase == 1) mx = 4'd1;
      else mx = 4'($urandom_range(1, 15));
      if (phase == 0) mn = 4'd1;
      else if (phase == 1) mn = 4'd15;
      else begin
        case ($urandom_range(0, 4))
          0: mn = 4'd1;
          1: mn = 4'd15;
          default: mn = 4'($urandom_range(2, 8));
        endcase
      end
      write_reg(CFG_MAX_ERRORS, mx);
      write_reg(CFG_MIN_NEW_LEN, mn);
      cur_min = int'(mn);
      phase_end = n_sent + $urandom_range(120, 260);
      saw_lock = 1'b0;
      while (n_sent < phase_end && n_sent < goal && !saw_lock) run_sequence();
    end

    wait_idle();
    repeat (TAIL) @(posedge clk);
    if (chk_errors == 0 && chk_left == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/kcl_pkg.sv
hdl/kcl_matcher.sv
hdl/keypad_code_lock_core.sv
test/kcl_lock_checker.sv
test/tb_keypad_code_lock_core.sv
